FILE: rtl/core/jsu_pkg.sv
// jsu_pkg: shared types and codes for the JSON string unescaper.
// Holds parse modes, result kinds and the queued per-item result list.
// No dependencies.
package jsu_pkg;

  localparam int MAX_RES = 7;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_STR,
    MODE_ESC,
    MODE_HEX,
    MODE_HELD,
    MODE_HELD_BS,
    MODE_LOW_HEX
  } mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
  } res_t;

  // All results caused by one input item, r[0] first
  typedef struct packed {
    logic [2:0]              n;
    res_t [MAX_RES-1:0]      r;
  } op_t;

  typedef struct packed {
    logic push;
    op_t  data;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    op_t  data;
  } q_rd_t;

endpackage

FILE: rtl/core/json_string_unescape_utf8_top.sv
// The first result of an item goes through the result queue and then the output register.
// Throughput: one input byte per cycle while the result queue has room; the back end
// sends one result per cycle while out_stall is low, taking an item's results in order.
// The queue holds QUEUE_DEPTH items; input stalls only while it is full.
// Reset: synchronous, active low; clears the parser to idle, empties the queue and
// drops output valid. No clearing pass.
module json_string_unescape_utf8_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_result_kind,
  output logic       out_run_last
);

  jsu_pkg::q_wr_t q_wr;
  jsu_pkg::q_rd_t q_rd;
  logic           q_full;
  logic           q_pop;

  assign in_stall = q_full;

  jsu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (q_full),
    .in_byte        (in_byte),
    .in_end_of_data (in_end_of_data),
    .q_wr           (q_wr)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .full  (q_full),
    .q_rd  (q_rd),
    .pop   (q_pop)
  );

  jsu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_rd            (q_rd),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_result_kind (out_result_kind),
    .out_run_last    (out_run_last)
  );

endmodule

FILE: rtl/core/jsu_front.sv
// jsu_front: accepts input bytes, runs the string parse state machine and
// builds the list of results each byte causes. Depends on jsu_pkg.
module jsu_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_stall,
  input  logic [7:0]      in_byte,
  input  logic            in_end_of_data,
  output jsu_pkg::q_wr_t  q_wr
);

  localparam logic [7:0]  CH_QUOTE = 8'h22;
  localparam logic [7:0]  CH_BSL   = 8'h5C;
  localparam logic [7:0]  CH_SLASH = 8'h2F;
  localparam logic [7:0]  CH_SPACE = 8'h20;
  localparam logic [7:0]  CH_TAB   = 8'h09;
  localparam logic [7:0]  CH_CR    = 8'h0D;
  localparam logic [7:0]  CH_LF    = 8'h0A;
  localparam logic [7:0]  CH_B     = 8'h62;
  localparam logic [7:0]  CH_F     = 8'h66;
  localparam logic [7:0]  CH_N     = 8'h6E;
  localparam logic [7:0]  CH_R     = 8'h72;
  localparam logic [7:0]  CH_T     = 8'h74;
  localparam logic [7:0]  CH_U     = 8'h75;
  localparam logic [7:0]  CH_0     = 8'h30;
  localparam logic [7:0]  CH_9     = 8'h39;
  localparam logic [7:0]  CH_LA    = 8'h61;
  localparam logic [7:0]  CH_LF_HX = 8'h66;
  localparam logic [7:0]  CH_UA    = 8'h41;
  localparam logic [7:0]  CH_UF    = 8'h46;
  localparam logic [15:0] HI_FIRST = 16'hD800;
  localparam logic [15:0] HI_LAST  = 16'hDBFF;
  localparam logic [15:0] LO_FIRST = 16'hDC00;
  localparam logic [15:0] LO_LAST  = 16'hDFFF;
  localparam logic [5:0]  SUR_TAG  = 6'b110110;
  localparam logic [20:0] PAIR_BASE = 21'h10000;

  function automatic jsu_pkg::op_t add_byte(jsu_pkg::op_t l, logic [7:0] d, logic [1:0] k);
    if (l.n < 3'(jsu_pkg::MAX_RES)) begin
      l.r[l.n] = '{data: d, kind: k};
      l.n      = l.n + 3'd1;
    end
    return l;
  endfunction

  function automatic jsu_pkg::op_t add_utf8(jsu_pkg::op_t l, logic [20:0] cp);
    logic [2:0]      n;
    logic [3:0][7:0] b;
    b = '0;
    if (cp < 21'h80) begin
      n    = 3'd1;
      b[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      n    = 3'd2;
      b[0] = {3'b110, cp[10:6]};
      b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      n    = 3'd3;
      b[0] = {4'b1110, cp[15:12]};
      b[1] = {2'b10, cp[11:6]};
      b[2] = {2'b10, cp[5:0]};
    end else begin
      n    = 3'd4;
      b[0] = {5'b11110, cp[20:18]};
      b[1] = {2'b10, cp[17:12]};
      b[2] = {2'b10, cp[11:6]};
      b[3] = {2'b10, cp[5:0]};
    end
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < n) l = add_byte(l, b[k], jsu_pkg::KIND_DATA);
    end
    return l;
  endfunction

  // Send a waiting high surrogate as a lone three-byte sequence
  function automatic jsu_pkg::op_t release_op(jsu_pkg::op_t l, logic f, logic [9:0] h);
    if (f) l = add_utf8(l, {5'd0, SUR_TAG, h});
    return l;
  endfunction

  jsu_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic [15:0]    acc_r, acc_nxt;
  logic [9:0]     hi_r, hi_nxt;
  logic           held_r, held_nxt;

  logic           accept;
  logic           hex_ok;
  logic [3:0]     hex_v;
  logic [15:0]    acc_new;
  logic [20:0]    pair_cp;
  logic           do_str, do_esc, do_fail, esc_ok;
  logic [7:0]     esc_v;
  jsu_pkg::op_t   ops;

  assign accept = in_valid && !in_stall;

  always_comb begin
    hex_ok = 1'b1;
    hex_v  = in_byte[3:0];
    if (in_byte >= CH_0 && in_byte <= CH_9) begin
      hex_v = in_byte[3:0];
    end else if ((in_byte >= CH_LA && in_byte <= CH_LF_HX) ||
                 (in_byte >= CH_UA && in_byte <= CH_UF)) begin
      hex_v = in_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign acc_new = {acc_r[11:0], hex_v};
  assign pair_cp = PAIR_BASE + {1'b0, hi_r, 10'd0} + {11'd0, acc_new[9:0]};

  always_comb begin
    esc_ok = 1'b1;
    esc_v  = in_byte;
    unique case (in_byte)
      CH_QUOTE, CH_BSL, CH_SLASH: esc_v = in_byte;
      CH_B:    esc_v = 8'h08;
      CH_F:    esc_v = 8'h0C;
      CH_N:    esc_v = 8'h0A;
      CH_R:    esc_v = 8'h0D;
      CH_T:    esc_v = 8'h09;
      default: esc_ok = 1'b0;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    hi_nxt   = hi_r;
    held_nxt = held_r;
    ops      = '0;
    do_str   = 1'b0;
    do_esc   = 1'b0;
    do_fail  = 1'b0;

    unique case (mode_r)
      jsu_pkg::MODE_IDLE: begin
        if (in_byte == CH_QUOTE) begin
          mode_nxt = jsu_pkg::MODE_STR;
        end else if (in_byte != CH_SPACE && in_byte != CH_TAB &&
                     in_byte != CH_CR && in_byte != CH_LF) begin
          do_fail = 1'b1;
        end
      end
      jsu_pkg::MODE_STR: do_str = 1'b1;
      jsu_pkg::MODE_ESC: do_esc = 1'b1;
      jsu_pkg::MODE_HEX, jsu_pkg::MODE_LOW_HEX: begin
        if (!hex_ok) begin
          ops      = release_op(ops, held_nxt, hi_nxt);
          held_nxt = 1'b0;
          hi_nxt   = '0;
          do_fail  = 1'b1;
        end else if (cnt_r != 2'd3) begin
          cnt_nxt = cnt_r + 2'd1;
          acc_nxt = acc_new;
        end else begin
          cnt_nxt = '0;
          acc_nxt = '0;
          if (mode_r == jsu_pkg::MODE_LOW_HEX && acc_new >= LO_FIRST && acc_new <= LO_LAST) begin
            ops      = add_utf8(ops, pair_cp);
            held_nxt = 1'b0;
            hi_nxt   = '0;
            mode_nxt = jsu_pkg::MODE_STR;
          end else begin
            ops      = release_op(ops, held_r, hi_r);
            held_nxt = 1'b0;
            hi_nxt   = '0;
            if (acc_new >= HI_FIRST && acc_new <= HI_LAST) begin
              hi_nxt   = acc_new[9:0];
              held_nxt = 1'b1;
              mode_nxt = jsu_pkg::MODE_HELD;
            end else begin
              ops      = add_utf8(ops, {5'd0, acc_new});
              mode_nxt = jsu_pkg::MODE_STR;
            end
          end
        end
      end
      jsu_pkg::MODE_HELD: begin
        if (in_byte == CH_BSL) begin
          mode_nxt = jsu_pkg::MODE_HELD_BS;
        end else begin
          ops      = release_op(ops, held_r, hi_r);
          held_nxt = 1'b0;
          hi_nxt   = '0;
          mode_nxt = jsu_pkg::MODE_STR;
          do_str   = 1'b1;
        end
      end
      jsu_pkg::MODE_HELD_BS: begin
        if (in_byte == CH_U) begin
          mode_nxt = jsu_pkg::MODE_LOW_HEX;
          cnt_nxt  = '0;
          acc_nxt  = '0;
        end else begin
          ops      = release_op(ops, held_r, hi_r);
          held_nxt = 1'b0;
          hi_nxt   = '0;
          do_esc   = 1'b1;
        end
      end
      default: do_fail = 1'b1;
    endcase

    if (do_str) begin
      if (in_byte == CH_QUOTE) begin
        ops      = add_byte(ops, 8'd0, jsu_pkg::KIND_DONE);
        mode_nxt = jsu_pkg::MODE_IDLE;
        cnt_nxt  = '0;
        acc_nxt  = '0;
        hi_nxt   = '0;
        held_nxt = 1'b0;
      end else if (in_byte == CH_BSL) begin
        mode_nxt = jsu_pkg::MODE_ESC;
      end else begin
        ops = add_byte(ops, in_byte, jsu_pkg::KIND_DATA);
      end
    end

    if (do_esc) begin
      mode_nxt = jsu_pkg::MODE_STR;
      if (in_byte == CH_U) begin
        mode_nxt = jsu_pkg::MODE_HEX;
        cnt_nxt  = '0;
        acc_nxt  = '0;
      end else if (esc_ok) begin
        ops = add_byte(ops, esc_v, jsu_pkg::KIND_DATA);
      end else begin
        do_fail = 1'b1;
      end
    end

    if (do_fail) begin
      ops      = add_byte(ops, 8'd0, jsu_pkg::KIND_ERROR);
      mode_nxt = jsu_pkg::MODE_IDLE;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      hi_nxt   = '0;
      held_nxt = 1'b0;
    end

    // Data ran out inside a string: flush any held surrogate, then error
    if (in_end_of_data && mode_nxt != jsu_pkg::MODE_IDLE) begin
      ops      = release_op(ops, held_nxt, hi_nxt);
      ops      = add_byte(ops, 8'd0, jsu_pkg::KIND_ERROR);
      mode_nxt = jsu_pkg::MODE_IDLE;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      hi_nxt   = '0;
      held_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jsu_pkg::MODE_IDLE;
      cnt_r  <= '0;
      acc_r  <= '0;
      hi_r   <= '0;
      held_r <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
      hi_r   <= hi_nxt;
      held_r <= held_nxt;
    end
  end

  // Items that cause no result never enter the queue
  assign q_wr.push = accept && (ops.n != 3'd0);
  assign q_wr.data = ops;

  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_end_of_data |=> mode_r == jsu_pkg::MODE_IDLE)
    else $error("end of data did not return parser to idle");

  a_held_mode: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> (mode_r == jsu_pkg::MODE_HELD || mode_r == jsu_pkg::MODE_HELD_BS ||
                mode_r == jsu_pkg::MODE_LOW_HEX))
    else $error("held surrogate outside pairing modes");

  a_cnt_mode: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd0 |-> (mode_r == jsu_pkg::MODE_HEX || mode_r == jsu_pkg::MODE_LOW_HEX))
    else $error("hex digit count outside hex modes");

endmodule

FILE: rtl/core/jsu_queue.sv
// jsu_queue: short queue of per-item result lists between front and back.
// Depends on jsu_pkg.
module jsu_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  jsu_pkg::q_wr_t  q_wr,
  output logic            full,
  output jsu_pkg::q_rd_t  q_rd,
  input  logic            pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jsu_pkg::op_t     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign q_rd.valid = (cnt_r != '0);
  assign q_rd.data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (q_wr.push) mem_r[wr_ptr_r] <= q_wr.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_wr.push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({q_wr.push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_rd.valid)
    else $error("pop from empty queue");

endmodule

FILE: rtl/core/jsu_back.sv
// jsu_back: walks the queued result lists and drives one result per cycle
// through the output register while out_stall is low. Depends on jsu_pkg.
module jsu_back (
  input  logic            clk,
  input  logic            rst_n,
  input  jsu_pkg::q_rd_t  q_rd,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_result_kind,
  output logic            out_run_last
);

  logic [2:0]    idx_r;
  logic          valid_r;
  logic [7:0]    byte_r;
  logic [1:0]    kind_r;
  logic          last_r;
  logic          load;
  logic          is_last;
  jsu_pkg::res_t cur;

  assign load    = q_rd.valid && (!valid_r || !out_stall);
  assign cur     = q_rd.data.r[idx_r];
  assign is_last = (idx_r == q_rd.data.n - 3'd1);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= is_last ? 3'd0 : idx_r + 3'd1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= cur.data;
      kind_r <= cur.kind;
      last_r <= is_last;
    end
  end

  assign out_valid       = valid_r;
  assign out_byte        = byte_r;
  assign out_result_kind = kind_r;
  assign out_run_last    = last_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd.valid |-> idx_r < q_rd.data.n)
    else $error("result index beyond list length");

  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !q_rd.valid |-> idx_r == 3'd0)
    else $error("result index left over with empty queue");

endmodule
